// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define HDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hds_pkg.sv =====
`default_nettype none

package hds_pkg;

    localparam int TEMP_W     = 16;              // Q8.8 temperature
    localparam int SIZE_W     = 7;               // grid size registers
    localparam int GAIN_W     = 15;              // Q0.16 gain, top bit always zero
    localparam int GAIN_FRAC  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int LAP_W      = TEMP_W + 3;      // signed five-point Laplacian
    localparam int PROD_W     = LAP_W + GAIN_W;  // signed gain * Laplacian
    localparam int TOT_W      = 2 * TEMP_W + 4;  // signed rounded sum before clamp

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_GAIN   = 2'd2;

    localparam logic [SIZE_W-1:0] GRID_WIDTH_RST  = 7'd64;
    localparam logic [SIZE_W-1:0] GRID_HEIGHT_RST = 7'd64;
    localparam logic [GAIN_W-1:0] DIFF_GAIN_RST   = 15'd0;

    typedef enum logic {
        PH_CLEAR,
        PH_RUN
    } t_phase;

endpackage

`default_nettype wire

// ===== hw/rtl/heat_diffusion_stencil_step.sv =====
`default_nettype none
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ---------------------------
// in        sink       i_in_valid / o_in_ready   i_cell_temp
// out       source     o_out_valid / i_out_ready o_new_temp, o_frame_end
// cfg       sink       i_cfg_we (no wait)        i_cfg_idx, i_cfg_wdata
//
// One cell per clock sustained while the output is not stalled; a cell passes the
// RAM output registers, stages 2 and 3 and the output register. The rate is set by
// the five frame-store reads per cell: three copies of the store (two read ports
// on two copies, one on the third) serve them all in the cycle the cell is taken.
// After reset a clearing pass zeroes all 2 * 2^clog2(MAX_HEIGHT) * 2^clog2(MAX_WIDTH)
// entries of the store (8192 at the defaults); no cell is taken meanwhile.
// Every pipeline stage holds on its own, so bubbles collapse under output stall.

`include "assert_macros.svh"

module heat_diffusion_stencil_step #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input cells
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [hds_pkg::TEMP_W-1:0]       i_cell_temp,
    // updated cells
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic      [hds_pkg::TEMP_W-1:0]       o_new_temp,
    output logic                                  o_frame_end,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [hds_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [hds_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import hds_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int AW = 1 + RW + CW;   // {bank, row, column}

    localparam logic signed [TOT_W-1:0] ROUND_HALF = TOT_W'(1) <<< (GAIN_FRAC - 1);

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic [SIZE_W-1:0] r_grid_width;
    logic [SIZE_W-1:0] r_grid_height;
    logic [GAIN_W-1:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
            r_gain        <= DIFF_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_wdata[SIZE_W-1:0];
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_wdata[SIZE_W-1:0];
                CFG_DIFF_GAIN:   r_gain        <= i_cfg_wdata[GAIN_W-1:0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // Effective size: zero acts as one, anything above the maximum as the maximum.
    logic [CW:0] w_eff;
    logic [RW:0] h_eff;

    always_comb begin
        if (r_grid_width == '0) begin
            w_eff = (CW+1)'(1);
        end else if (32'(r_grid_width) > 32'(MAX_WIDTH)) begin
            w_eff = (CW+1)'(MAX_WIDTH);
        end else begin
            w_eff = (CW+1)'(r_grid_width);
        end
        if (r_grid_height == '0) begin
            h_eff = (RW+1)'(1);
        end else if (32'(r_grid_height) > 32'(MAX_HEIGHT)) begin
            h_eff = (RW+1)'(MAX_HEIGHT);
        end else begin
            h_eff = (RW+1)'(r_grid_height);
        end
    end

    // ---------------------------------------------------------------
    // Clearing pass after reset
    // ---------------------------------------------------------------
    t_phase          r_phase, n_phase;
    logic [AW-1:0]   r_clr_addr, n_clr_addr;
    logic            clr_active;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_CLEAR: if (&r_clr_addr) n_phase = PH_RUN;
            PH_RUN:   n_phase = PH_RUN;
            default:  n_phase = PH_CLEAR;
        endcase
    end

    always_comb begin
        unique case (r_phase)
            PH_CLEAR: clr_active = 1'b1;
            PH_RUN:   clr_active = 1'b0;
            default:  clr_active = 1'b1;
        endcase
    end

    assign n_clr_addr = clr_active ? r_clr_addr + AW'(1) : r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_phase    <= n_phase;
            r_clr_addr <= n_clr_addr;
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: each stage advances when empty or when the
    // stage after it advances.
    // ---------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic en1, en2, en3, en_out;
    logic in_acc;

    assign en_out     = !r_out_valid || i_out_ready;
    assign en3        = !r_s3_valid || en_out;
    assign en2        = !r_s2_valid || en3;
    assign en1        = !r_s1_valid || en2;
    assign o_in_ready = en1 && !clr_active;
    assign in_acc     = i_in_valid && o_in_ready;

    // ---------------------------------------------------------------
    // Raster position and neighbor addresses
    // ---------------------------------------------------------------
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic          r_bank;   // bank being filled; the other holds the previous frame

    logic [CW:0]   col_inc;
    logic [RW:0]   row_inc;
    logic          row_end, frame_last;
    logic [CW-1:0] col_left, col_right;
    logic [RW-1:0] row_up, row_down;

    always_comb begin
        col_inc    = {1'b0, r_col} + (CW+1)'(1);
        row_inc    = {1'b0, r_row} + (RW+1)'(1);
        row_end    = (col_inc >= w_eff);
        frame_last = row_end && (row_inc >= h_eff);
        // wrap neighbors around the torus of the size in use
        col_left   = (r_col == '0) ? CW'(w_eff - (CW+1)'(1)) : r_col - CW'(1);
        col_right  = row_end ? '0 : col_inc[CW-1:0];
        row_up     = (r_row == '0) ? RW'(h_eff - (RW+1)'(1)) : r_row - RW'(1);
        row_down   = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_bank <= 1'b0;
        end else if (in_acc) begin
            if (frame_last) begin
                r_row  <= '0;
                r_col  <= '0;
                r_bank <= !r_bank;
            end else if (row_end) begin
                r_row <= row_inc[RW-1:0];
                r_col <= '0;
            end else begin
                r_col <= col_inc[CW-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // Frame store: three copies, all written alike. Reads go to the
    // previous bank and the write to the current one, so a cell never
    // reads the entry written in the same cycle; every entry it reads
    // was written at an earlier edge and no forwarding is needed.
    // ---------------------------------------------------------------
    logic                        mem_we;
    logic [AW-1:0]               mem_wr_addr;
    logic [TEMP_W-1:0]           mem_wr_data;
    logic [1:0][AW-1:0]          vert_addr, horz_addr;
    logic [0:0][AW-1:0]          ctr_addr;
    logic [1:0][TEMP_W-1:0]      vert_data, horz_data;
    logic [0:0][TEMP_W-1:0]      ctr_data;

    always_comb begin
        mem_we       = clr_active || in_acc;
        mem_wr_addr  = clr_active ? r_clr_addr : {r_bank, r_row, r_col};
        mem_wr_data  = clr_active ? '0 : i_cell_temp;
        vert_addr[0] = {!r_bank, row_up,   r_col};
        vert_addr[1] = {!r_bank, row_down, r_col};
        horz_addr[0] = {!r_bank, r_row,    col_left};
        horz_addr[1] = {!r_bank, r_row,    col_right};
        ctr_addr[0]  = {!r_bank, r_row,    r_col};
    end

    hds_ram #(.ADDR_W(AW), .RD_PORTS(2)) u_ram_vert (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (in_acc),
        .i_rd_addr (vert_addr),
        .o_rd_data (vert_data)
    );

    hds_ram #(.ADDR_W(AW), .RD_PORTS(2)) u_ram_horz (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (in_acc),
        .i_rd_addr (horz_addr),
        .o_rd_data (horz_data)
    );

    hds_ram #(.ADDR_W(AW), .RD_PORTS(1)) u_ram_ctr (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (in_acc),
        .i_rd_addr (ctr_addr),
        .o_rd_data (ctr_data)
    );

    // ---------------------------------------------------------------
    // Stage 1: read data sits in the RAM output registers (loaded only
    // on acceptance, so they hold while the stage stalls).
    // ---------------------------------------------------------------
    logic r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= in_acc;
        end
        if (in_acc) begin
            r_s1_last <= frame_last;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: Laplacian up + down + left + right - 4u
    // ---------------------------------------------------------------
    logic signed [LAP_W-1:0] lap;
    logic signed [LAP_W-1:0] r_s2_lap;
    logic [TEMP_W-1:0]       r_s2_u;
    logic                    r_s2_last;

    assign lap = $signed({3'b000, vert_data[0]}) + $signed({3'b000, vert_data[1]})
               + $signed({3'b000, horz_data[0]}) + $signed({3'b000, horz_data[1]})
               - $signed({1'b0, ctr_data[0], 2'b00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
        if (en2 && r_s1_valid) begin
            r_s2_lap  <= lap;
            r_s2_u    <= ctr_data[0];
            r_s2_last <= r_s1_last;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: gain times Laplacian
    // ---------------------------------------------------------------
    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] product;
    logic signed [PROD_W-1:0] r_s3_prod;
    logic [TEMP_W-1:0]        r_s3_u;
    logic                     r_s3_last;

    assign gain_s  = $signed({1'b0, r_gain});
    assign product = PROD_W'(gain_s) * PROD_W'(r_s2_lap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en3) begin
            r_s3_valid <= r_s2_valid;
        end
        if (en3 && r_s2_valid) begin
            r_s3_prod <= product;
            r_s3_u    <= r_s2_u;
            r_s3_last <= r_s2_last;
        end
    end

    // ---------------------------------------------------------------
    // Output stage: u*2^16 + product, round half up, clamp to 16 bits
    // ---------------------------------------------------------------
    logic signed [TOT_W-1:0] total;
    logic [TEMP_W-1:0]       result;
    logic [TEMP_W-1:0]       r_new_temp;
    logic                    r_frame_end;

    always_comb begin
        total = $signed({4'b0000, r_s3_u, GAIN_FRAC'(0)}) + TOT_W'(r_s3_prod) + ROUND_HALF;
        if (total[TOT_W-1]) begin
            result = '0;
        end else if (|total[TOT_W-2:GAIN_FRAC+TEMP_W]) begin
            result = '1;
        end else begin
            result = total[GAIN_FRAC+TEMP_W-1:GAIN_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s3_valid;
        end
        if (en_out && r_s3_valid) begin
            r_new_temp  <= result;
            r_frame_end <= r_s3_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_new_temp  = r_new_temp;
    assign o_frame_end = r_frame_end;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `HDS_ASSERT_NEXT(a_clear_ends, i_clk, i_rst_n,
        (r_phase == PH_CLEAR) && (&r_clr_addr), r_phase == PH_RUN,
        "clearing pass did not finish on the last address")
    `HDS_ASSERT_NEXT(a_run_holds, i_clk, i_rst_n,
        r_phase == PH_RUN, r_phase == PH_RUN,
        "clearing restarted without reset")
    `HDS_ASSERT_NEXT(a_frame_wrap, i_clk, i_rst_n,
        in_acc && frame_last,
        (r_row == '0) && (r_col == '0) && (r_bank != $past(r_bank)),
        "last cell of frame did not wrap position and swap banks")
    `HDS_ASSERT_IMPL(a_acc_not_clear, i_clk, i_rst_n,
        in_acc, !mem_we || (mem_wr_addr[AW-1] == r_bank),
        "cell write missed the bank being filled")

endmodule

`default_nettype wire

// ===== hw/rtl/hds_ram.sv =====
`default_nettype none

module hds_ram #(
    parameter int ADDR_W   = 13,
    parameter int RD_PORTS = 2
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [ADDR_W-1:0]                         i_wr_addr,
    input  wire logic [hds_pkg::TEMP_W-1:0]                i_wr_data,
    input  wire logic                                      i_rd_en,
    input  wire logic [RD_PORTS-1:0][ADDR_W-1:0]           i_rd_addr,
    output logic      [RD_PORTS-1:0][hds_pkg::TEMP_W-1:0]  o_rd_data
);
    import hds_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [TEMP_W-1:0]                r_mem [DEPTH];
    logic [RD_PORTS-1:0][TEMP_W-1:0]  r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            for (int p = 0; p < RD_PORTS; p++) begin
                r_rd_data[p] <= r_mem[i_rd_addr[p]];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== tb/sv/heat_diffusion_stencil_step_checker.sv =====
`timescale 1ns / 1ps

module heat_diffusion_stencil_step_checker #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [hds_pkg::TEMP_W-1:0]     i_cell_temp,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [hds_pkg::TEMP_W-1:0]     i_new_temp,
    input  logic                           i_frame_end,
    input  logic                           i_cfg_we,
    input  logic [hds_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hds_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                             o_fail_count,
    output int                             o_pending
);
    import hds_pkg::*;

    localparam int BANK_CELLS = MAX_WIDTH * MAX_HEIGHT;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic              frame_end;
    } t_cell_result;

    logic [TEMP_W-1:0] frame_mem [0:2*BANK_CELLS-1];
    int                row_pos;
    int                col_pos;
    logic              bank_sel;
    logic [SIZE_W-1:0] grid_w;
    logic [SIZE_W-1:0] grid_h;
    logic [GAIN_W-1:0] gain;
    t_cell_result      pending_cells [$];

    function automatic longint stored_temp(logic bank, int r, int c);
        return longint'(frame_mem[int'(bank) * BANK_CELLS + r * MAX_WIDTH + c]);
    endfunction

    // Store the incoming cell and return the update of the same cell of the
    // previous frame; advance the raster position.
    function automatic t_cell_result diffuse_cell(logic [TEMP_W-1:0] incoming);
        int           w;
        int           h;
        int           r;
        int           c;
        int           lt;
        int           rt;
        int           up;
        int           dn;
        logic         prev;
        longint       u;
        longint       lap;
        longint       total;
        bit           row_end;
        t_cell_result res;

        w = (grid_w == 0) ? 1 : ((grid_w > MAX_WIDTH) ? MAX_WIDTH : int'(grid_w));
        h = (grid_h == 0) ? 1 : ((grid_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(grid_h));
        r = (row_pos >= MAX_HEIGHT) ? MAX_HEIGHT - 1 : row_pos;
        c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
        prev = ~bank_sel;

        // Wrap neighbors around the grid edges
        lt = (c == 0) ? w - 1 : c - 1;
        rt = (c + 1 >= w) ? 0 : c + 1;
        up = (r == 0) ? h - 1 : r - 1;
        dn = (r + 1 >= h) ? 0 : r + 1;

        u = stored_temp(prev, r, c);
        lap = stored_temp(prev, up, c) + stored_temp(prev, dn, c)
            + stored_temp(prev, r, lt) + stored_temp(prev, r, rt) - 4 * u;
        total = u * 65536 + longint'(gain) * lap + 32768;
        if (total < 0) begin
            res.temp = '0;
        end else if ((total >>> 16) > 65535) begin
            res.temp = '1;
        end else begin
            res.temp = total[31:16];
        end

        frame_mem[int'(bank_sel) * BANK_CELLS + r * MAX_WIDTH + c] = incoming;

        row_end = (c + 1 >= w);
        res.frame_end = row_end && (r + 1 >= h);
        if (res.frame_end) begin
            row_pos = 0;
            col_pos = 0;
            bank_sel = ~bank_sel;
        end else if (row_end) begin
            col_pos = 0;
            row_pos = r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_cell_result want;
        bit           bad;

        if (!i_rst_n) begin
            for (int i = 0; i < 2 * BANK_CELLS; i++) begin
                frame_mem[i] = '0;
            end
            row_pos = 0;
            col_pos = 0;
            bank_sel = 1'b0;
            grid_w = GRID_WIDTH_RST;
            grid_h = GRID_HEIGHT_RST;
            gain = DIFF_GAIN_RST;
            pending_cells.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GRID_WIDTH: begin
                        grid_w = i_cfg_wdata[SIZE_W-1:0];
                    end
                    CFG_GRID_HEIGHT: begin
                        grid_h = i_cfg_wdata[SIZE_W-1:0];
                    end
                    CFG_DIFF_GAIN: begin
                        gain = i_cfg_wdata[GAIN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            // Compare before pushing, so a result never matches its own cell
            if (i_out_valid && i_out_ready) begin
                if (pending_cells.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected transaction, expected none, got temp %h end %b",
                             $time, i_new_temp, i_frame_end);
                end else begin
                    want = pending_cells.pop_front();
                    bad = 1'b0;
                    if (i_new_temp !== want.temp) begin
                        bad = 1'b1;
                        $display("%0t: new_temp mismatch, expected %h, got %h",
                                 $time, want.temp, i_new_temp);
                    end
                    if (i_frame_end !== want.frame_end) begin
                        bad = 1'b1;
                        $display("%0t: frame_end mismatch, expected %b, got %b",
                                 $time, want.frame_end, i_frame_end);
                    end
                    if (bad) begin
                        o_fail_count++;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                pending_cells.push_back(diffuse_cell(i_cell_temp));
            end
        end
        o_pending = pending_cells.size();
    end

endmodule

// ===== tb/sv/heat_diffusion_stencil_step_tb.sv =====
`timescale 1ns / 1ps

module heat_diffusion_stencil_step_tb;
    import hds_pkg::*;

    localparam int MAX_W        = 64;
    localparam int MAX_H        = 64;
    localparam int RANDOM_CELLS = 2000;
    // Index with no register behind it: the block must ignore the write
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [TEMP_W-1:0]     i_cell_temp = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [TEMP_W-1:0]     o_new_temp;
    logic                  o_frame_end;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    int fail_count;
    int pending;
    int gap_pct = 0;     // chance in a hundred that the sender idles a cycle
    int stall_pct = 0;   // chance in a hundred that the receiver stalls a cycle
    int cells_sent = 0;

    always #1 i_clk = ~i_clk;

    heat_diffusion_stencil_step #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cell_temp (i_cell_temp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_new_temp  (o_new_temp),
        .o_frame_end (o_frame_end),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    heat_diffusion_stencil_step_checker #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_cell_temp  (i_cell_temp),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_new_temp   (o_new_temp),
        .i_frame_end  (o_frame_end),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: one decision per falling edge, stall at the current rate
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard stop: clearing pass plus every cell at the slowest idling mix,
    // taken many times over
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Offer one cell and hold it until the transaction completes. Called and
    // returns at a falling edge; valid stays high so back-to-back cells never
    // drop it in between.
    task automatic send_cell(input logic [TEMP_W-1:0] temp);
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cell_temp <= temp;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        @(negedge i_clk);
        cells_sent++;
    endtask

    // Stop offering cells and hold until every predicted cell has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Write all three registers back to back; only call while drained.
    // Junk goes into the unused upper bits of the size writes.
    task automatic configure(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                             input logic [GAIN_W-1:0] g, input bit poke_spare);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_GRID_WIDTH;
        i_cfg_wdata <= {8'($urandom), w};
        @(negedge i_clk);
        i_cfg_idx <= CFG_GRID_HEIGHT;
        i_cfg_wdata <= {8'($urandom), h};
        @(negedge i_clk);
        i_cfg_idx <= CFG_DIFF_GAIN;
        i_cfg_wdata <= g;
        @(negedge i_clk);
        if (poke_spare) begin
            i_cfg_idx <= CFG_SPARE_IDX;
            i_cfg_wdata <= CFG_DATA_W'($urandom);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [TEMP_W-1:0] directed [0:17];
        logic [SIZE_W-1:0] raw_w;
        logic [SIZE_W-1:0] raw_h;
        logic [GAIN_W-1:0] g;
        logic [TEMP_W-1:0] base;
        logic [TEMP_W-1:0] temp;
        int                eff_w;
        int                eff_h;
        int                cells;
        int                phase;
        int                pick;

        directed = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                     16'h5555, 16'hAAAA, 16'h8000, 16'hFFFF, 16'h0000, 16'hFFFF,
                     16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF, 16'h0100};

        // Synchronous reset held from time zero, then released at a falling edge
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: a few cells under the reset sizes and zero gain; the
        // first frame after reset must come out as zeros
        for (int i = 0; i < 3; i++) begin
            send_cell(16'hFFFF);
        end

        // Shrink to 3x3 mid-row: the current column is past the new last one,
        // so the row ends at once. Quarter gain gives plain neighbor averaging.
        wait_drained();
        configure(7'd3, 7'd3, 15'd16384, 1'b1);
        for (int i = 0; i < 18; i++) begin
            send_cell(directed[i]);
        end

        // Width zero acts as one, height above the maximum acts as the
        // maximum; gain above a quarter drives results into both clamps
        wait_drained();
        configure(7'd0, 7'd127, 15'd32767, 1'b0);
        send_cell(16'hFFFF);
        send_cell(16'h0000);
        send_cell(16'hFFFF);
        send_cell(16'h0000);

        // Random phases: rotate the idling mix, mostly small grids with a few
        // at the largest size along one axis
        phase = 0;
        while (cells_sent < RANDOM_CELLS + 25) begin
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 51; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 51; end
                default: begin gap_pct = 20; stall_pct = 20; end
            endcase

            pick = $urandom_range(9);
            case (pick)
                0: begin
                    raw_w = $urandom_range(1) ? 7'd64 : 7'($urandom_range(65, 127));
                    raw_h = 7'($urandom_range(0, 2));
                end
                1: begin
                    raw_w = 7'($urandom_range(0, 2));
                    raw_h = $urandom_range(1) ? 7'd64 : 7'($urandom_range(65, 127));
                end
                2: begin
                    raw_w = 7'($urandom_range(0, 1));
                    raw_h = 7'($urandom_range(0, 6));
                end
                default: begin
                    raw_w = 7'($urandom_range(1, 8));
                    raw_h = 7'($urandom_range(1, 8));
                end
            endcase
            case ($urandom_range(4))
                0: g = '0;
                1: g = 15'd16384;
                2: g = 15'd32767;
                3: g = 15'($urandom_range(16384));
                default: g = 15'($urandom_range(32767));
            endcase

            eff_w = (raw_w == 0) ? 1 : ((raw_w > MAX_W) ? MAX_W : int'(raw_w));
            eff_h = (raw_h == 0) ? 1 : ((raw_h > MAX_H) ? MAX_H : int'(raw_h));
            // Two or three frames, plus a partial one so the next phase
            // sometimes resizes mid-frame
            cells = eff_w * eff_h * $urandom_range(2, 3)
                  + $urandom_range(0, eff_w * eff_h - 1);
            base = 16'($urandom);

            wait_drained();
            configure(raw_w, raw_h, g, phase % 5 == 0);

            for (int k = 0; k < cells; k++) begin
                // Once, let the pipeline empty completely mid-phase
                if (phase == 2 && k == cells / 2) begin
                    wait_drained();
                end
                pick = $urandom_range(9);
                if (pick < 5) begin
                    temp = base + 16'($urandom_range(0, 511));
                end else if (pick < 8) begin
                    temp = 16'($urandom);
                end else if (pick == 8) begin
                    temp = '0;
                end else begin
                    temp = '1;
                end
                send_cell(temp);
            end
            phase++;
        end

        // Drain, then give the pipeline its latency and a margin
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
